@@ hw/rtl/vl2n_pkg.sv @@
// Shared widths, register indexes and store sizing for the L2 vector normalizer.
// No dependencies; imported by vector_l2_normalize.
`default_nettype none

package vl2n_pkg;

    localparam int COMP_W      = 24;   // Q8.16 component
    localparam int UNIT_W      = 18;   // Q1.16 unit component
    localparam int MAG_W       = 27;   // Q.16 magnitude
    localparam int LEN_W       = 7;
    localparam int MINMAG_W    = 16;
    localparam int FRAC_W      = 16;
    localparam int QUOT_W      = FRAC_W + 1;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SQ_W        = 2 * COMP_W;
    localparam int SUM_W       = 2 * MAG_W;       // even width for the root digit pairs
    localparam int REM_W       = MAG_W + FRAC_W;  // shared subtractor width

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_MAGNITUDE = 8'd1;

    localparam logic [LEN_W-1:0]    VECTOR_LENGTH_RESET = 7'd16;
    localparam logic [MINMAG_W-1:0] MIN_MAGNITUDE_RESET = 16'd1;

    localparam logic [QUOT_W-1:0] UNIT_ONE = 17'd65536;

endpackage

`default_nettype wire

@@ hw/rtl/vl2n_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vl2n_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/vector_l2_normalize.sv @@
// L2 normalizer top level: component store, sum of squares, shared compare/subtract unit.
// Depends on vl2n_pkg and vl2n_ram.
`default_nettype none

// Usage:
//   Input: present a Q8.16 component on component_in and raise start; the word is
//   taken at a rising edge with start high and busy low. Each word is stored and its
//   square added to a running sum. A word that does not complete the vector keeps
//   busy high through the square and accumulate states before the next is taken.
//   With the word that completes the vector (vector_length words, 0 acts as 1,
//   above 64 acts as 64) the block runs a bit-pair square root, then emits one
//   result per stored component: a store read, an operand load, 17 restoring
//   divide steps and the output cycle. One shared 43-bit compare/subtract unit
//   serves both the root and the divides.
//   Output: result_valid is high for exactly one cycle per result; unit_component,
//   vector_magnitude and is_last are valid in that cycle. The receiver cannot stall.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is high only
//   while idle and start is low. Writing vector_length drops a partial vector.
//   Reset: asynchronous, active low; registers return to 16 and 1, the fill count
//   and sum clear. The store needs no clearing pass.
module vector_l2_normalize (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [vl2n_pkg::COMP_W-1:0]  component_in,
    output logic                                     result_valid,
    output logic signed [vl2n_pkg::UNIT_W-1:0]       unit_component,
    output logic        [vl2n_pkg::MAG_W-1:0]        vector_magnitude,
    output logic                                     is_last,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic   [vl2n_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic   [vl2n_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import vl2n_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQUARE = 3'd1;
    localparam logic [2:0] ST_ACCUM  = 3'd2;
    localparam logic [2:0] ST_SQRT   = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_LOAD   = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    localparam logic [4:0] SQRT_STEPS_M1 = 5'(MAG_W - 1);
    localparam logic [4:0] DIV_STEPS_M1  = 5'(QUOT_W - 1);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(STORE_DEPTH);

    logic [2:0]              state_reg, state_next;
    logic [LEN_W-1:0]        vlen_reg, vlen_next;
    logic [MINMAG_W-1:0]     minmag_reg, minmag_next;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic [LEN_W-1:0]        count_reg, count_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic [4:0]              step_reg, step_next;
    logic [COMP_W-1:0]       abs_reg, abs_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [SUM_W-1:0]        x_reg, x_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [REM_W-1:0]        dsr_reg, dsr_next;
    logic [MAG_W-1:0]        mag_reg, mag_next;
    logic [QUOT_W-1:0]       q_reg, q_next;
    logic                    sign_reg, sign_next;

    logic                    accept;
    logic                    cfg_write;
    logic [LEN_W-1:0]        len_eff;
    logic [COMP_W-1:0]       rd_data;
    logic [COMP_W-1:0]       rd_abs;
    logic [REM_W-1:0]        sub_a;
    logic [REM_W-1:0]        sub_b;
    logic [REM_W:0]          diff;
    logic                    ge;
    logic [REM_W-1:0]        root_rem;
    logic [SUM_W-1:0]        sum_add;
    logic [QUOT_W-1:0]       q_sat;
    logic                    zero_out;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy && !start;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        priority if (vlen_reg == '0)
            len_eff = LEN_W'(1);
        else if (vlen_reg > DEPTH_LEN)
            len_eff = DEPTH_LEN;
        else
            len_eff = vlen_reg;
    end

    vl2n_ram #(
        .WIDTH (COMP_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (component_in),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    assign rd_abs  = rd_data[COMP_W-1] ? (~rd_data + COMP_W'(1)) : rd_data;
    assign sum_add = sum_reg + SUM_W'(sq_reg);

    // Shared compare/subtract: root trial in SQRT, shifted divisor otherwise.
    assign root_rem = {rem_reg[REM_W-3:0], x_reg[SUM_W-1 -: 2]};
    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            sub_a = root_rem;
            sub_b = REM_W'({mag_reg, 2'b01});
        end
        else
        begin
            sub_a = rem_reg;
            sub_b = dsr_reg;
        end
    end
    assign diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge   = !diff[REM_W];

    always_comb
    begin
        state_next  = state_reg;
        vlen_next   = vlen_reg;
        minmag_next = minmag_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        step_next   = step_reg;
        abs_next    = abs_reg;
        sq_next     = sq_reg;
        sum_next    = sum_reg;
        x_next      = x_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        mag_next    = mag_reg;
        q_next      = q_reg;
        sign_next   = sign_reg;

        if (cfg_write)
        begin
            if (cfg_index == REG_VECTOR_LENGTH)
            begin
                vlen_next = cfg_data[LEN_W-1:0];
                fill_next = '0;
                sum_next  = '0;
            end
            else if (cfg_index == REG_MIN_MAGNITUDE)
            begin
                minmag_next = cfg_data[MINMAG_W-1:0];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    abs_next   = component_in[COMP_W-1] ?
                                 (~component_in + COMP_W'(1)) : component_in;
                    fill_next  = fill_reg + LEN_W'(1);
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                sq_next    = abs_reg * abs_reg;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                if (fill_reg >= len_eff)
                begin
                    // vector complete: hand the sum to the root and clear for the next one
                    x_next     = sum_add;
                    sum_next   = '0;
                    count_next = fill_reg;
                    fill_next  = '0;
                    rem_next   = '0;
                    mag_next   = '0;
                    step_next  = SQRT_STEPS_M1;
                    state_next = ST_SQRT;
                end
                else
                begin
                    sum_next   = sum_add;
                    state_next = ST_IDLE;
                end
            end
            ST_SQRT:
            begin
                rem_next = ge ? diff[REM_W-1:0] : root_rem;
                mag_next = {mag_reg[MAG_W-2:0], ge};
                x_next   = {x_reg[SUM_W-3:0], 2'b00};
                if (step_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = ST_READ;
                end
                else
                begin
                    step_next = step_reg - 5'd1;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rem_next   = REM_W'({rd_abs, {FRAC_W{1'b0}}});
                dsr_next   = REM_W'({mag_reg, {FRAC_W{1'b0}}});
                sign_next  = rd_data[COMP_W-1];
                q_next     = '0;
                step_next  = DIV_STEPS_M1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = ge ? diff[REM_W-1:0] : rem_reg;
                q_next   = {q_reg[QUOT_W-2:0], ge};
                dsr_next = {1'b0, dsr_reg[REM_W-1:1]};
                if (step_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg - 5'd1;
                end
            end
            ST_EMIT:
            begin
                if (is_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            vlen_reg   <= VECTOR_LENGTH_RESET;
            minmag_reg <= MIN_MAGNITUDE_RESET;
            fill_reg   <= '0;
            sum_reg    <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            vlen_reg   <= vlen_next;
            minmag_reg <= minmag_next;
            fill_reg   <= fill_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        abs_reg  <= abs_next;
        sq_reg   <= sq_next;
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        mag_reg  <= mag_next;
        q_reg    <= q_next;
        sign_reg <= sign_next;
    end

    // Saturate at 1.0, apply the sign, zero the unit component for tiny magnitudes.
    assign q_sat    = (q_reg > UNIT_ONE) ? UNIT_ONE : q_reg;
    assign zero_out = (mag_reg == '0) || (mag_reg < MAG_W'(minmag_reg));

    always_comb
    begin
        if (zero_out)
            unit_component = '0;
        else if (sign_reg)
            unit_component = -$signed({1'b0, q_sat});
        else
            unit_component = $signed({1'b0, q_sat});
    end

    assign result_valid     = (state_reg == ST_EMIT);
    assign vector_magnitude = mag_reg;
    assign is_last          = ((LEN_W'(idx_reg) + LEN_W'(1)) == count_reg);

    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result strobe outside a busy period");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start work");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((unit_component <= 18'sd65536) && (unit_component >= -18'sd65536)))
        else $error("unit component beyond one");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_last) |=> !busy)
        else $error("block still busy after last result");

    a_zero_mag_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (vector_magnitude == '0)) |-> (unit_component == '0))
        else $error("nonzero unit component with zero magnitude");

endmodule

`default_nettype wire
